// ===== rtl/tsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, widths and register indexes of the trapezoid speed profile.
// ----------------------------------------------------------------------------
package tsp_pkg;

	localparam int POS_W      = 24;
	localparam int SPEED_W    = 14;
	localparam int FRAC_W     = 17;
	localparam int FRAC_SHIFT = 16;
	localparam int SQ_W       = 2 * SPEED_W;
	localparam int DEN_W      = POS_W + FRAC_W;
	localparam int PROD_W     = SQ_W + POS_W;
	localparam int DIV_STEPS  = SQ_W;
	localparam int SQRT_STEPS = SPEED_W;

	localparam logic [FRAC_W-1:0]  FRAC_ONE  = FRAC_W'(1 << FRAC_SHIFT);
	localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

	// register indexes of the configuration port
	localparam logic [2:0] REG_START_POS   = 3'd0;
	localparam logic [2:0] REG_END_POS     = 3'd1;
	localparam logic [2:0] REG_START_SPEED = 3'd2;
	localparam logic [2:0] REG_PEAK_SPEED  = 3'd3;
	localparam logic [2:0] REG_FINISH_SPD  = 3'd4;
	localparam logic [2:0] REG_ACCEL_FRAC  = 3'd5;
	localparam logic [2:0] REG_DECEL_FRAC  = 3'd6;

	// profile phase as reported on the output
	typedef enum logic [2:0] {
		PH_INVALID = 3'd0,
		PH_CONST   = 3'd1,
		PH_BEFORE  = 3'd2,
		PH_PAST    = 3'd3,
		PH_ACCEL   = 3'd4,
		PH_CRUISE  = 3'd5,
		PH_DECEL   = 3'd6
	} phase_t;

	typedef struct packed {
		logic signed [POS_W-1:0] start_position;
		logic signed [POS_W-1:0] end_position;
		logic [SPEED_W-1:0]      start_speed;
		logic [SPEED_W-1:0]      peak_speed;
		logic [SPEED_W-1:0]      finish_speed;
		logic [FRAC_W-1:0]       accel_fraction;
		logic [FRAC_W-1:0]       decel_fraction;
	} cfg_t;

	// classified item; kind PH_ACCEL stands for "somewhere on the path"
	typedef struct packed {
		phase_t             kind;
		logic               rev;
		logic [POS_W-1:0]   s;
		logic [POS_W-1:0]   ssu;
	} item_t;

	// side information that rides along the arithmetic pipeline
	typedef struct packed {
		phase_t             phase;
		logic [SPEED_W-1:0] speed;
		logic               neg;
		logic               use_div;
	} sb_t;

	typedef struct packed {
		sb_t             sb;
		logic [SQ_W-1:0] base;
		logic            sub;
	} div_tag_t;

endpackage

// ===== rtl/trapezoid_speed_profile_by_position.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_speed_profile_by_position
// Target speed from a position-based trapezoidal profile.
// ----------------------------------------------------------------------------
// One position beat is taken per clock and one result beat leaves per clock
// while the output is not stalled. An accepted position beat lands in the
// classify queue at the accepting edge, then passes four stages of products
// and bounds, a 28-stage divider producing one quotient bit per stage, one
// add stage, a 14-stage square root producing one root bit per stage and the
// output register. The whole arithmetic pipeline holds while a result waits
// on m_tready; the two-entry input queue takes beats until it is full.
// Registers are to be written through cfg_we/cfg_addr/cfg_wdata only while
// no beats are in flight; the block itself does not enforce this.
module trapezoid_speed_profile_by_position import tsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // position[23:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // target_speed[14:0], zero pad[15]
	output logic [2:0]  m_tuser,   // phase[2:0]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_wdata
);

	cfg_t                  cfg_q;
	logic                  head_valid;
	item_t                 head;
	logic                  pop;
	logic signed [SPEED_W:0] target_speed;
	phase_t                phase;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_START_POS:   cfg_q.start_position <= cfg_wdata[POS_W-1:0];
				REG_END_POS:     cfg_q.end_position   <= cfg_wdata[POS_W-1:0];
				REG_START_SPEED: cfg_q.start_speed    <= cfg_wdata[SPEED_W-1:0];
				REG_PEAK_SPEED:  cfg_q.peak_speed     <= cfg_wdata[SPEED_W-1:0];
				REG_FINISH_SPD:  cfg_q.finish_speed   <= cfg_wdata[SPEED_W-1:0];
				REG_ACCEL_FRAC:  cfg_q.accel_fraction <= cfg_wdata[FRAC_W-1:0];
				REG_DECEL_FRAC:  cfg_q.decel_fraction <= cfg_wdata[FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	tsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.position   (s_tdata),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tsp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.target_speed (target_speed),
		.phase        (phase)
	);

	assign m_tdata = {1'b0, target_speed};
	assign m_tuser = phase;

endmodule

// ===== rtl/tsp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_front
// Accepts position beats, classifies them against the profile and queues them.
// ----------------------------------------------------------------------------
module tsp_front import tsp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [POS_W-1:0] position,
	input  logic                    pop,
	output logic                    head_valid,
	output item_t                   head
);

	logic                  rev;
	logic                  invalid;
	logic signed [POS_W:0] dse;
	logic signed [POS_W:0] dsp;
	item_t                 item;
	item_t                 mem_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            cnt_q;
	logic                  push;
	logic                  do_pop;

	// classification of the incoming position
	always_comb begin
		dse = (POS_W+1)'(cfg.end_position) - (POS_W+1)'(cfg.start_position);
		dsp = (POS_W+1)'(position) - (POS_W+1)'(cfg.start_position);
		rev = cfg.end_position < cfg.start_position;
		invalid = (cfg.accel_fraction > FRAC_ONE) || (cfg.decel_fraction > FRAC_ONE) ||
			(cfg.peak_speed < cfg.start_speed);
		item.rev = rev;
		item.ssu = dse[POS_W] ? POS_W'(-dse) : dse[POS_W-1:0];
		item.s   = dsp[POS_W] ? POS_W'(-dsp) : dsp[POS_W-1:0];
		if (invalid) begin
			item.kind = PH_INVALID;
		end else if (cfg.start_position == cfg.end_position) begin
			item.kind = PH_CONST;
		end else if (rev ? (position > cfg.start_position) : (position < cfg.start_position)) begin
			item.kind = PH_BEFORE;
		end else if (rev ? (position < cfg.end_position) : (position > cfg.end_position)) begin
			item.kind = PH_PAST;
		end else begin
			item.kind = PH_ACCEL;
		end
	end

	// two-entry queue towards the arithmetic part
	assign in_ready   = cnt_q != 2'd2;
	assign push       = in_valid && in_ready;
	assign head_valid = cnt_q != 2'd0;
	assign do_pop     = pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end

endmodule

// ===== rtl/tsp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tsp_div import tsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  div_tag_t          in_tag,
	input  logic [PROD_W-1:0] num,
	input  logic [DEN_W-1:0]  den,
	output logic              out_valid,
	output div_tag_t          out_tag,
	output logic [SQ_W-1:0]   quo
);

	// numerator is the product shifted up by the FRAC_SHIFT fraction bits
	localparam int LOW_W = DIV_STEPS;

	logic [DIV_STEPS-1:0] valid_q;
	div_tag_t             tag_q [DIV_STEPS];
	logic [DEN_W-1:0]     rem_q [DIV_STEPS];
	logic [LOW_W-1:0]     low_q [DIV_STEPS];
	logic [SQ_W-1:0]      quo_q [DIV_STEPS];
	logic [DEN_W-1:0]     den_q [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic             v_in;
		div_tag_t         t_in;
		logic [DEN_W-1:0] r_in;
		logic [LOW_W-1:0] l_in;
		logic [SQ_W-1:0]  q_in;
		logic [DEN_W-1:0] d_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign t_in = in_tag;
			assign r_in = DEN_W'(num[PROD_W-1:LOW_W-FRAC_SHIFT]);
			assign l_in = {num[LOW_W-FRAC_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};
			assign q_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign v_in = valid_q[k-1];
			assign t_in = tag_q[k-1];
			assign r_in = rem_q[k-1];
			assign l_in = low_q[k-1];
			assign q_in = quo_q[k-1];
			assign d_in = den_q[k-1];
		end

		// shift in the next numerator bit and try the subtraction
		assign trial = {r_in, l_in[LOW_W-1]};
		assign ge    = trial >= {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? DEN_W'(trial - {1'b0, d_in}) : trial[DEN_W-1:0];
				low_q[k] <= {l_in[LOW_W-2:0], 1'b0};
				quo_q[k] <= {q_in[SQ_W-2:0], ge};
				den_q[k] <= d_in;
				tag_q[k] <= t_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[k] <= 1'b0;
			end else if (en) begin
				valid_q[k] <= v_in;
			end
		end
	end

	assign out_valid = valid_q[DIV_STEPS-1];
	assign out_tag   = tag_q[DIV_STEPS-1];
	assign quo       = quo_q[DIV_STEPS-1];

endmodule

// ===== rtl/tsp_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tsp_sqrt import tsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  sb_t                in_sb,
	input  logic [SQ_W-1:0]    x,
	output logic               out_valid,
	output sb_t                out_sb,
	output logic [SPEED_W-1:0] root
);

	localparam int T_W = SQ_W + 2;

	logic [SQRT_STEPS-1:0] valid_q;
	sb_t                   sb_q   [SQRT_STEPS];
	logic [SQ_W-1:0]       rem_q  [SQRT_STEPS];
	logic [SPEED_W-1:0]    root_q [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam int J = SQRT_STEPS - 1 - k;
		logic               v_in;
		sb_t                s_in;
		logic [SQ_W-1:0]    r_in;
		logic [SPEED_W-1:0] o_in;
		logic [T_W-1:0]     trial;
		logic               ge;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign s_in = in_sb;
			assign r_in = x;
			assign o_in = '0;
		end else begin : g_next
			assign v_in = valid_q[k-1];
			assign s_in = sb_q[k-1];
			assign r_in = rem_q[k-1];
			assign o_in = root_q[k-1];
		end

		// remainder holds x minus root squared; try setting bit J
		assign trial = (T_W'(o_in) << (J + 1)) + (T_W'(1) << (2 * J));
		assign ge    = T_W'(r_in) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? SQ_W'(T_W'(r_in) - trial) : r_in;
				root_q[k] <= ge ? (o_in | (SPEED_W'(1) << J)) : o_in;
				sb_q[k]   <= s_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[k] <= 1'b0;
			end else if (en) begin
				valid_q[k] <= v_in;
			end
		end
	end

	assign out_valid = valid_q[SQRT_STEPS-1];
	assign out_sb    = sb_q[SQRT_STEPS-1];
	assign root      = root_q[SQRT_STEPS-1];

endmodule

// ===== rtl/tsp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_back
// Arithmetic pipeline: phase bounds, products, division, square root, output.
// ----------------------------------------------------------------------------
module tsp_back import tsp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  head_valid,
	input  item_t                 head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [SPEED_W:0] target_speed,
	output phase_t                phase
);

	logic en;

	// stage 1 products
	logic               valid_s1;
	item_t              it_s1;
	logic [DEN_W-1:0]   sac_s1;
	logic [DEN_W-1:0]   sde_s1;
	logic [SQ_W-1:0]    v0sq_s1;
	logic [SQ_W-1:0]    vmsq_s1;
	logic [SQ_W-1:0]    vesq_s1;
	logic [SQ_W-1:0]    cp_s1;

	// stage 2 bounds
	logic               valid_s2;
	item_t              it_s2;
	logic               acc_s2;
	logic [DEN_W-1:0]   lim_s2;
	logic [DEN_W-1:0]   sac_s2;
	logic [DEN_W-1:0]   sde_s2;
	logic [SQ_W-1:0]    v0sq_s2;
	logic [SQ_W-1:0]    vmsq_s2;
	logic [SQ_W-1:0]    vesq_s2;
	logic [SPEED_W-1:0] cp_s2;

	// stage 3 decision
	logic               valid_s3;
	logic [SQ_W-1:0]    d_s3;
	logic [POS_W-1:0]   x_s3;
	logic [DEN_W-1:0]   c_s3;
	div_tag_t           tag_s3;
	div_tag_t           tag_c;
	logic [SQ_W-1:0]    d_c;
	logic [POS_W-1:0]   x_c;
	logic [DEN_W-1:0]   c_c;
	logic [DEN_W-1:0]   s16_c;

	// stage 4 product
	logic               valid_s4;
	logic [PROD_W-1:0]  prod_s4;
	logic [DEN_W-1:0]   c_s4;
	div_tag_t           tag_s4;

	// after divider and square root
	logic               div_valid;
	div_tag_t           div_tag;
	logic [SQ_W-1:0]    quo;
	logic               valid_s5;
	sb_t                sb_s5;
	logic [SQ_W-1:0]    sq_s5;
	logic               sq_valid;
	sb_t                sq_sb;
	logic [SPEED_W-1:0] root;
	logic [SPEED_W-1:0] spd;

	logic               out_valid_q;
	logic signed [SPEED_W:0] speed_q;
	phase_t             phase_q;

	// whole pipeline advances while the output register can take a beat
	assign en  = !out_valid_q || out_ready;
	assign pop = en && head_valid;

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1   <= head;
			sac_s1  <= DEN_W'(head.ssu) * DEN_W'(cfg.accel_fraction);
			sde_s1  <= DEN_W'(head.ssu) * DEN_W'(cfg.decel_fraction);
			v0sq_s1 <= SQ_W'(cfg.start_speed) * SQ_W'(cfg.start_speed);
			vmsq_s1 <= SQ_W'(cfg.peak_speed) * SQ_W'(cfg.peak_speed);
			vesq_s1 <= SQ_W'(cfg.finish_speed) * SQ_W'(cfg.finish_speed);
			cp_s1   <= SQ_W'(cfg.start_speed) * SQ_W'(cfg.peak_speed);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2   <= it_s1;
			acc_s2  <= DEN_W'({it_s1.s, {FRAC_SHIFT{1'b0}}}) < sac_s1;
			lim_s2  <= DEN_W'({it_s1.ssu, {FRAC_SHIFT{1'b0}}}) - sde_s1;
			sac_s2  <= sac_s1;
			sde_s2  <= sde_s1;
			v0sq_s2 <= v0sq_s1;
			vmsq_s2 <= vmsq_s1;
			vesq_s2 <= vesq_s1;
			cp_s2   <= (cp_s1 > SQ_W'(SPEED_MAX)) ? SPEED_MAX : cp_s1[SPEED_W-1:0];
		end
	end

	// phase decision and divider operands
	always_comb begin
		s16_c          = DEN_W'({it_s2.s, {FRAC_SHIFT{1'b0}}});
		d_c            = '0;
		x_c            = '0;
		c_c            = DEN_W'(1);
		tag_c.base     = '0;
		tag_c.sub      = 1'b0;
		tag_c.sb.use_div = 1'b0;
		tag_c.sb.speed = '0;
		tag_c.sb.phase = it_s2.kind;
		unique case (it_s2.kind)
			PH_INVALID: tag_c.sb.speed = '0;
			PH_CONST:   tag_c.sb.speed = cp_s2;
			PH_BEFORE:  tag_c.sb.speed = cfg.start_speed;
			PH_PAST:    tag_c.sb.speed = cfg.finish_speed;
			default: begin
				if (acc_s2) begin
					tag_c.sb.phase   = PH_ACCEL;
					tag_c.sb.use_div = 1'b1;
					d_c        = vmsq_s2 - v0sq_s2;
					x_c        = it_s2.s;
					c_c        = sac_s2;
					tag_c.base = v0sq_s2;
				end else if (s16_c < lim_s2) begin
					tag_c.sb.phase = PH_CRUISE;
					tag_c.sb.speed = cfg.peak_speed;
				end else begin
					tag_c.sb.phase = PH_DECEL;
					if (sde_s2 == '0) begin
						tag_c.sb.speed = cfg.finish_speed;
					end else begin
						tag_c.sb.use_div = 1'b1;
						x_c        = it_s2.ssu - it_s2.s;
						c_c        = sde_s2;
						tag_c.base = vesq_s2;
						if (cfg.peak_speed >= cfg.finish_speed) begin
							d_c = vmsq_s2 - vesq_s2;
						end else begin
							d_c       = vesq_s2 - vmsq_s2;
							tag_c.sub = 1'b1;
						end
					end
				end
			end
		endcase
		tag_c.sb.neg = it_s2.rev && (it_s2.kind != PH_INVALID) && (it_s2.kind != PH_CONST);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3    <= d_c;
			x_s3    <= x_c;
			c_s3    <= c_c;
			tag_s3  <= tag_c;
			prod_s4 <= PROD_W'(d_s3) * PROD_W'(x_s3);
			c_s4    <= c_s3;
			tag_s4  <= tag_s3;
		end
	end

	tsp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s4),
		.in_tag    (tag_s4),
		.num       (prod_s4),
		.den       (c_s4),
		.out_valid (div_valid),
		.out_tag   (div_tag),
		.quo       (quo)
	);

	// add the quotient onto, or subtract it from, the base speed squared
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s5 <= div_tag.sb;
			sq_s5 <= div_tag.sub ? (div_tag.base - quo) : (div_tag.base + quo);
		end
	end

	tsp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s5),
		.in_sb     (sb_s5),
		.x         (sq_s5),
		.out_valid (sq_valid),
		.out_sb    (sq_sb),
		.root      (root)
	);

	assign spd = sq_sb.use_div ? root : sq_sb.speed;

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			speed_q <= sq_sb.neg ? -$signed({1'b0, spd}) : $signed({1'b0, spd});
			phase_q <= sq_sb.phase;
		end
	end

	// valid bits of the front stages and the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= head_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= div_valid;
			out_valid_q <= sq_valid;
		end
	end

	assign out_valid    = out_valid_q;
	assign target_speed = speed_q;
	assign phase        = phase_q;

endmodule

// ===== dv/tb_trapezoid_speed_profile_by_position.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trapezoid_speed_profile_by_position
// Self-checking bench for the position-driven trapezoidal speed profile.
// ----------------------------------------------------------------------------
// Position beats go in on the slave stream and speed/phase beats come back on
// the master stream. A scoreboard predicts every result from its own copy of
// the profile registers and checks the beats in order. The run walks through
// several register settings: a normal forward path, reversed travel, equal
// end points, invalid settings, zero and overlapping shares and random ones,
// with random gaps on both sides and one long receiver stall.
module tb_trapezoid_speed_profile_by_position;
	import tsp_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 60;
	localparam int NUM_SETTINGS = 11;
	localparam int RAND_PER_SET = 150;

	typedef struct packed {
		logic [15:0] tdata;
		logic [2:0]  tuser;
	} speed_beat_t;

	// --------------------------------------------------------------------
	// scoreboard: profile prediction and in-order comparison
	// --------------------------------------------------------------------
	class speed_scoreboard;
		cfg_t        regs;
		speed_beat_t pending[$];

		function logic [63:0] root_floor(logic [63:0] x);
			logic [63:0] r;
			logic [63:0] b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function speed_beat_t profile_speed(logic signed [23:0] pos);
			speed_beat_t  res;
			logic signed [63:0] ps, pe, p;
			logic [63:0]  v0, vm, ve, spd, ssu, s, s16, ssu16, sac16, sde16, rest, d;
			logic [127:0] num;
			logic         rev;
			phase_t       ph;
			ps  = regs.start_position;
			pe  = regs.end_position;
			p   = pos;
			v0  = regs.start_speed;
			vm  = regs.peak_speed;
			ve  = regs.finish_speed;
			rev = pe < ps;
			res = '0;
			// invalid settings win over everything
			if (regs.accel_fraction > FRAC_ONE || regs.decel_fraction > FRAC_ONE || vm < v0) begin
				res.tuser = PH_INVALID;
				return res;
			end
			// zero-length path
			if (ps == pe) begin
				spd = v0 * vm;
				if (spd > SPEED_MAX) spd = SPEED_MAX;
				res.tdata = spd[15:0];
				res.tuser = PH_CONST;
				return res;
			end
			if ((!rev && p < ps) || (rev && p > ps)) begin
				spd = v0;
				ph  = PH_BEFORE;
			end else if ((!rev && p > pe) || (rev && p < pe)) begin
				spd = ve;
				ph  = PH_PAST;
			end else begin
				ssu   = rev ? ps - pe : pe - ps;
				s     = (p >= ps) ? p - ps : ps - p;
				s16   = s << 16;
				ssu16 = ssu << 16;
				sac16 = ssu * regs.accel_fraction;
				sde16 = ssu * regs.decel_fraction;
				if (s16 < sac16) begin
					d   = vm * vm - v0 * v0;
					num = (128'(d) * 128'(s16)) / 128'(sac16);
					spd = root_floor(v0 * v0 + num[63:0]);
					ph  = PH_ACCEL;
				end else if (s16 < ssu16 - sde16) begin
					spd = vm;
					ph  = PH_CRUISE;
				end else begin
					rest = ssu16 - s16;
					ph   = PH_DECEL;
					if (sde16 == 0) begin
						spd = ve;
					end else if (vm >= ve) begin
						d   = vm * vm - ve * ve;
						num = (128'(d) * 128'(rest)) / 128'(sde16);
						spd = root_floor(ve * ve + num[63:0]);
					end else begin
						d   = ve * ve - vm * vm;
						num = (128'(d) * 128'(rest)) / 128'(sde16);
						spd = root_floor(ve * ve - num[63:0]);
					end
				end
			end
			if (spd > SPEED_MAX) spd = SPEED_MAX;
			if (rev) spd = 64'd0 - spd;
			res.tdata = {1'b0, spd[14:0]};
			res.tuser = ph;
			return res;
		endfunction

		function void note_position(logic [23:0] pos);
			pending.push_back(profile_speed(pos));
		endfunction

		// empty string when the beat matches
		function string check_beat(logic [15:0] tdata, logic [2:0] tuser);
			speed_beat_t exp_beat;
			string       msg;
			if (pending.size() == 0) return "result beat with none expected";
			exp_beat = pending.pop_front();
			msg = "";
			if (tdata !== exp_beat.tdata)
				msg = $sformatf("target_speed got %h exp %h ", tdata, exp_beat.tdata);
			if (tuser !== exp_beat.tuser)
				msg = {msg, $sformatf("phase got %0d exp %0d", tuser, exp_beat.tuser)};
			return msg;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;    // position[23:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;    // target_speed[14:0], zero pad[15]
	logic [2:0]  m_tuser;    // phase[2:0]
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [23:0] cfg_wdata;

	speed_scoreboard board;
	int          mismatches;
	int          idle_cycles;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_request;

	trapezoid_speed_profile_by_position i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// monitor: note accepted positions, check result beats, watch for stalls
	always @(posedge clk) begin
		string msg;
		if (arst_n) begin
			if (s_tvalid && s_tready) board.note_position(s_tdata);
			if (m_tvalid && m_tready) begin
				msg = board.check_beat(m_tdata, m_tuser);
				if (msg != "") report(msg);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("no beat moved for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				for (n = 0; n < 400; n++) @(posedge clk);
				hold_request = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// write every profile register, one per clock
	task automatic write_profile(cfg_t c);
		logic [23:0] vals[7];
		vals[REG_START_POS]   = c.start_position;
		vals[REG_END_POS]     = c.end_position;
		vals[REG_START_SPEED] = 24'(c.start_speed);
		vals[REG_PEAK_SPEED]  = 24'(c.peak_speed);
		vals[REG_FINISH_SPD]  = 24'(c.finish_speed);
		vals[REG_ACCEL_FRAC]  = 24'(c.accel_fraction);
		vals[REG_DECEL_FRAC]  = 24'(c.decel_fraction);
		for (int i = 0; i < 7; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= 3'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		board.regs = c;
	endtask

	// offer one position beat and wait for it to be taken
	task automatic send_position(logic [23:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pos;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// position mostly on or near the path, sometimes anywhere
	function automatic logic [23:0] pick_position(cfg_t c);
		int lo, hi, r;
		lo = (c.start_position < c.end_position) ? c.start_position : c.end_position;
		hi = (c.start_position < c.end_position) ? c.end_position : c.start_position;
		r  = $urandom_range(99);
		if (r < 10) return c.start_position;
		if (r < 20) return c.end_position;
		if (r < 30) return 24'($urandom);
		if (r < 40) return 24'(lo - 1 - $urandom_range(300));
		if (r < 50) return 24'(hi + 1 + $urandom_range(300));
		return 24'(lo + $urandom_range(hi - lo));
	endfunction

	function automatic cfg_t profile_setting(int idx);
		cfg_t c;
		c = '0;
		case (idx)
			0: c = '{0, 25600, 100, 3000, 50, 16384, 16384};
			// reversed, full-range path with fully overlapping shares
			1: c = '{24'sh7fffff, 24'sh800000, 0, 16383, 16383, 65536, 65536};
			// equal end points, product saturates
			2: c = '{5000, 5000, 200, 300, 7, 100, 100};
			// invalid share
			3: c = '{0, 4000, 10, 20, 30, 131071, 0};
			// peak below start
			4: c = '{-200, 800, 500, 400, 100, 1000, 1000};
			// zero shares, end point lands in deceleration
			5: c = '{-100, 900, 16383, 16383, 0, 0, 0};
			// finish above peak, overlapping shares, reversed
			6: c = '{1000, -3000, 10, 2000, 9000, 30000, 40000};
			// shortest path
			7: c = '{0, 1, 0, 16383, 0, 65535, 1};
			8: c = '{3, 3, 3, 7, 0, 65536, 65536};
			// invalid deceleration share
			10: c = '{0, 100, 0, 0, 0, 0, 65537};
			default: begin
				c.start_position = 24'($urandom);
				c.end_position   = 24'($urandom);
				c.start_speed    = $urandom_range(16383);
				c.peak_speed     = $urandom_range(16383, c.start_speed);
				c.finish_speed   = $urandom_range(16383);
				c.accel_fraction = $urandom_range(65536);
				c.decel_fraction = $urandom_range(65536);
			end
		endcase
		return c;
	endfunction

	// wait until every expected result is back, then let the pipeline empty
	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// main sequence
	initial begin
		cfg_t        c;
		logic [23:0] directed[$];
		board         = new();
		board.regs    = '0;
		mismatches    = 0;
		idle_cycles   = 0;
		hold_request  = 1'b0;
		send_idle_pct = 24;
		recv_idle_pct = 60;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes and every phase boundary of the forward path
		directed = '{24'h800000, 24'h7fffff, 0, 25600, 24'hffffff, 25601, 6400, 6399,
			6401, 12800, 19200, 19199, 25599, 1, 3200, 22400, 24'h555555, 24'haaaaaa};
		for (int k = 0; k < NUM_SETTINGS; k++) begin
			if (k == 4) begin
				send_idle_pct = 60;
				recv_idle_pct = 24;
			end else if (k == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			c = profile_setting(k);
			write_profile(c);
			if (k == 0) foreach (directed[j]) send_position(directed[j]);
			if (k == 5) hold_request = 1'b1;
			for (int j = 0; j < RAND_PER_SET; j++) send_position(pick_position(c));
			s_tvalid <= 1'b0;
			drain();
		end

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
